@@ hdl/rpa_pkg.sv @@
package rpa_pkg;

  // Fixed field widths of the channels and the configuration register.
  localparam int ACTION_W    = 2;
  localparam int ADDRESS_W   = 28;
  localparam int STATUS_W    = 3;
  localparam int PAGE_ADDR_W = 27;
  localparam int FREE_W      = 16;
  localparam int CFG_W       = 16;

  // Default sizing, handed to the top level.
  localparam int DEF_NUM_PAGES  = 32768;
  localparam int DEF_PAGE_SHIFT = 12;
  localparam int DEF_COUNT_BITS = 8;

  // Actions.
  localparam logic [ACTION_W-1:0] ACT_ALLOC  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REFINC = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_INIT   = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RESERVED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BEYOND     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW  = 3'd6;

  // Outcome of the address check for free and refinc.
  typedef struct packed {
    logic                ok;
    logic [STATUS_W-1:0] status;
  } chk_t;

endpackage

@@ hdl/refcounted_page_allocator.sv @@
// Reference-counted page allocator.
// Input items carry an action (alloc, free, reference increment, init) and a
// page byte address; every item yields exactly one result item with a status,
// the allocated page address, a released flag and the free-stack depth.
// Both channels use valid/ready. The free-page stack and the per-page counts
// live in two synchronous RAMs with registered read data.
// Alloc, free and refinc read the count and the stack top in IDLE as they are
// accepted; in EXEC they are checked, written back and loaded into the output
// register. No new item is accepted until the block has left EXEC.
// Init sweeps the pages from first_usable_page to NUM_PAGES-1, one page per
// cycle through both RAM write ports.
// After reset the count RAM is cleared one entry per cycle while in_ready is
// low; configuration writes are taken during that time.
// A result waits in the output register while out_ready is low; the next item
// is still accepted and is worked on up to its write back, where it waits for
// the output register to empty.
// first_usable_page is written through cfg_write_en/cfg_write_data; the user
// must write it only while the block is idle, which the block does not enforce.
module refcounted_page_allocator #(
  parameter int NUM_PAGES  = rpa_pkg::DEF_NUM_PAGES,
  parameter int PAGE_SHIFT = rpa_pkg::DEF_PAGE_SHIFT,
  parameter int COUNT_BITS = rpa_pkg::DEF_COUNT_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_write_en,
  input  logic [rpa_pkg::CFG_W-1:0]       cfg_write_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rpa_pkg::ACTION_W-1:0]    in_action,
  input  logic [rpa_pkg::ADDRESS_W-1:0]   in_address,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rpa_pkg::STATUS_W-1:0]    out_status,
  output logic [rpa_pkg::PAGE_ADDR_W-1:0] out_page_address,
  output logic                            out_page_released,
  output logic [rpa_pkg::FREE_W-1:0]      out_free_pages
);
  import rpa_pkg::*;

  localparam int PG_W    = $clog2(NUM_PAGES);
  localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
  localparam int FIRST_W = (DEPTH_W > CFG_W) ? DEPTH_W : CFG_W;
  localparam int PA_FULL = PG_W + PAGE_SHIFT;
  localparam int PA_W    = (PA_FULL > PAGE_ADDR_W) ? PA_FULL : PAGE_ADDR_W;
  localparam int FP_W    = (DEPTH_W > FREE_W) ? DEPTH_W : FREE_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_INIT  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [DEPTH_W-1:0]    depth_r, depth_nxt;
  logic [DEPTH_W-1:0]    sweep_r, sweep_nxt;
  logic [CFG_W-1:0]      first_r;
  logic [ACTION_W-1:0]   act_r;
  logic [PG_W-1:0]       page_r;
  chk_t                  chk_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [PAGE_ADDR_W-1:0] out_pa_r, out_pa_nxt;
  logic                  out_rel_r, out_rel_nxt;
  logic [FREE_W-1:0]     out_free_r, out_free_nxt;

  chk_t                  chk;
  logic [PG_W-1:0]       chk_page;
  logic                  accept;
  logic                  slot_free;
  logic                  emit;

  logic                  cnt_we, cnt_re;
  logic [PG_W-1:0]       cnt_waddr, cnt_raddr;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
  logic                  stk_we, stk_re;
  logic [PG_W-1:0]       stk_waddr, stk_raddr;
  logic [PG_W-1:0]       stk_wdata, stk_rdata;

  logic [DEPTH_W-1:0]    depth_m1;
  logic [FIRST_W-1:0]    first_w;
  logic [PA_W-1:0]       pa_wide;
  logic [FP_W-1:0]       fp_wide;

  rpa_check #(
    .NUM_PAGES (NUM_PAGES),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) u_check (
    .address          (in_address),
    .first_usable_page(first_r),
    .chk              (chk),
    .page             (chk_page)
  );

  rpa_ram #(
    .DEPTH(NUM_PAGES),
    .WIDTH(COUNT_BITS)
  ) u_count_ram (
    .clk  (clk),
    .we   (cnt_we),
    .waddr(cnt_waddr),
    .wdata(cnt_wdata),
    .re   (cnt_re),
    .raddr(cnt_raddr),
    .rdata(cnt_rdata)
  );

  rpa_ram #(
    .DEPTH(NUM_PAGES),
    .WIDTH(PG_W)
  ) u_stack_ram (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(stk_wdata),
    .re   (stk_re),
    .raddr(stk_raddr),
    .rdata(stk_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign depth_m1  = depth_r - DEPTH_W'(1);
  assign first_w   = FIRST_W'(first_r);

  // Reads are issued on acceptance: the count of the addressed page and
  // the entry on top of the stack.
  assign cnt_re    = accept;
  assign cnt_raddr = chk_page;
  assign stk_re    = accept;
  assign stk_raddr = depth_m1[PG_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    depth_nxt      = depth_r;
    sweep_nxt      = sweep_r;
    emit           = 1'b0;
    out_status_nxt = out_status_r;
    out_pa_nxt     = out_pa_r;
    out_rel_nxt    = out_rel_r;
    cnt_we         = 1'b0;
    cnt_waddr      = sweep_r[PG_W-1:0];
    cnt_wdata      = '0;
    stk_we         = 1'b0;
    stk_waddr      = depth_r[PG_W-1:0];
    stk_wdata      = sweep_r[PG_W-1:0];
    pa_wide        = PA_W'({stk_rdata, {PAGE_SHIFT{1'b0}}});

    case (state_r)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        sweep_nxt = sweep_r + DEPTH_W'(1);
        if (sweep_r == DEPTH_W'(NUM_PAGES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_action == ACT_INIT) begin
            depth_nxt = '0;
            if (first_w >= FIRST_W'(NUM_PAGES)) begin
              state_nxt = S_FIN;
            end else begin
              sweep_nxt = first_w[DEPTH_W-1:0];
              state_nxt = S_INIT;
            end
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          emit           = 1'b1;
          state_nxt      = S_IDLE;
          out_status_nxt = ST_OK;
          out_pa_nxt     = '0;
          out_rel_nxt    = 1'b0;
          case (act_r)
            ACT_ALLOC: begin
              if (depth_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                depth_nxt  = depth_m1;
                cnt_we     = 1'b1;
                cnt_waddr  = stk_rdata;
                cnt_wdata  = COUNT_BITS'(1);
                out_pa_nxt = pa_wide[PAGE_ADDR_W-1:0];
              end
            end
            ACT_FREE: begin
              if (!chk_r.ok) begin
                out_status_nxt = chk_r.status;
              end else if (cnt_rdata == '0) begin
                out_status_nxt = ST_UNDERFLOW;
              end else if (cnt_rdata == COUNT_BITS'(1)
                           && depth_r == DEPTH_W'(NUM_PAGES)) begin
                out_status_nxt = ST_OVERFLOW;
              end else begin
                cnt_we    = 1'b1;
                cnt_waddr = page_r;
                cnt_wdata = cnt_rdata - COUNT_BITS'(1);
                if (cnt_rdata == COUNT_BITS'(1)) begin
                  // Last reference gone: the page goes back on the stack.
                  stk_we      = 1'b1;
                  stk_wdata   = page_r;
                  depth_nxt   = depth_r + DEPTH_W'(1);
                  out_rel_nxt = 1'b1;
                end
              end
            end
            ACT_REFINC: begin
              if (!chk_r.ok) begin
                out_status_nxt = chk_r.status;
              end else if (&cnt_rdata) begin
                out_status_nxt = ST_OVERFLOW;
              end else begin
                cnt_we    = 1'b1;
                cnt_waddr = page_r;
                cnt_wdata = cnt_rdata + COUNT_BITS'(1);
              end
            end
            default: begin
              out_status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_INIT: begin
        // Page sweep_r goes to stack slot depth_r with its count cleared.
        cnt_we    = 1'b1;
        stk_we    = 1'b1;
        depth_nxt = depth_r + DEPTH_W'(1);
        sweep_nxt = sweep_r + DEPTH_W'(1);
        if (sweep_r == DEPTH_W'(NUM_PAGES - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          emit           = 1'b1;
          state_nxt      = S_IDLE;
          out_status_nxt = ST_OK;
          out_pa_nxt     = '0;
          out_rel_nxt    = 1'b0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    fp_wide      = FP_W'(depth_nxt);
    out_free_nxt = emit ? fp_wide[FREE_W-1:0] : out_free_r;

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      depth_r     <= '0;
      sweep_r     <= '0;
      first_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write_en) begin
        first_r <= cfg_write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= in_action;
      page_r <= chk_page;
      chk_r  <= chk;
    end
    out_status_r <= out_status_nxt;
    out_pa_r     <= out_pa_nxt;
    out_rel_r    <= out_rel_nxt;
    out_free_r   <= out_free_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_page_address  = out_pa_r;
  assign out_page_released = out_rel_r;
  assign out_free_pages    = out_free_r;

endmodule

@@ hdl/rpa_ram.sv @@
module rpa_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data is held until the next read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/rpa_check.sv @@
module rpa_check #(
  parameter int NUM_PAGES  = rpa_pkg::DEF_NUM_PAGES,
  parameter int PAGE_SHIFT = rpa_pkg::DEF_PAGE_SHIFT
) (
  input  logic [rpa_pkg::ADDRESS_W-1:0] address,
  input  logic [rpa_pkg::CFG_W-1:0]     first_usable_page,
  output rpa_pkg::chk_t                 chk,
  output logic [$clog2(NUM_PAGES)-1:0]  page
);
  import rpa_pkg::*;

  localparam int PG_W    = $clog2(NUM_PAGES);
  localparam int PGA_W   = ADDRESS_W - PAGE_SHIFT;
  localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
  localparam int MAX_A   = (PGA_W > CFG_W) ? PGA_W : CFG_W;
  localparam int CMP_W   = (MAX_A > DEPTH_W) ? MAX_A : DEPTH_W;

  logic [CMP_W-1:0] pg_w;
  logic [CMP_W-1:0] first_w;
  logic             misaligned;

  always_comb begin
    pg_w       = CMP_W'(address[ADDRESS_W-1:PAGE_SHIFT]);
    first_w    = CMP_W'(first_usable_page);
    misaligned = |address[PAGE_SHIFT-1:0];
    chk.ok     = 1'b0;
    if (misaligned) begin
      chk.status = ST_MISALIGNED;
    end else if (pg_w < first_w) begin
      chk.status = ST_RESERVED;
    end else if (pg_w >= CMP_W'(NUM_PAGES)) begin
      chk.status = ST_BEYOND;
    end else begin
      chk.status = ST_OK;
      chk.ok     = 1'b1;
    end
  end

  assign page = pg_w[PG_W-1:0];

endmodule

@@ tb/sv/rpa_result_checker.sv @@
module rpa_result_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_write_en,
  input  logic [rpa_pkg::CFG_W-1:0]       cfg_write_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [rpa_pkg::ACTION_W-1:0]    in_action,
  input  logic [rpa_pkg::ADDRESS_W-1:0]   in_address,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [rpa_pkg::STATUS_W-1:0]    out_status,
  input  logic [rpa_pkg::PAGE_ADDR_W-1:0] out_page_address,
  input  logic                            out_page_released,
  input  logic [rpa_pkg::FREE_W-1:0]      out_free_pages,
  output int                              mismatches,
  output int                              outstanding
);
  import rpa_pkg::*;

  localparam int PAGES      = DEF_NUM_PAGES;
  localparam int SHIFT      = DEF_PAGE_SHIFT;
  localparam int COUNT_BITS = DEF_COUNT_BITS;
  localparam int PAGE_W     = $clog2(PAGES);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [PAGE_ADDR_W-1:0] page_address;
    logic                   released;
    logic [FREE_W-1:0]      free_pages;
  } page_result_t;

  // Shadow copy of the allocator state.
  logic [PAGE_W-1:0]     page_stack [PAGES];
  logic [COUNT_BITS-1:0] page_refs [PAGES];
  logic [FREE_W-1:0]     stack_depth;
  logic [CFG_W-1:0]      first_page;

  page_result_t expected_page_results[$];
  int           errors_seen = 0;

  assign mismatches = errors_seen;

  function automatic page_result_t predict_page_op(input logic [ACTION_W-1:0] action,
                                                   input logic [ADDRESS_W-1:0] address);
    page_result_t        r;
    logic [STATUS_W-1:0] chk;
    int unsigned         pg;
    int unsigned         p;
    r  = '0;
    pg = 32'(address >> SHIFT);
    // The address checks apply in a fixed order: alignment, reserved, range.
    if (address[SHIFT-1:0] != '0) chk = ST_MISALIGNED;
    else if (pg < first_page) chk = ST_RESERVED;
    else if (pg >= PAGES) chk = ST_BEYOND;
    else chk = ST_OK;
    case (action)
      ACT_ALLOC: begin
        if (stack_depth == 0) begin
          r.status = ST_EMPTY;
        end else begin
          stack_depth--;
          p = 32'(page_stack[stack_depth]);
          page_refs[p] = COUNT_BITS'(1);
          r.page_address = PAGE_ADDR_W'(p << SHIFT);
        end
      end
      ACT_FREE: begin
        r.status = chk;
        if (chk == ST_OK) begin
          if (page_refs[pg] == 0) begin
            r.status = ST_UNDERFLOW;
          end else if (page_refs[pg] == 1 && stack_depth >= PAGES) begin
            r.status = ST_OVERFLOW;
          end else begin
            page_refs[pg]--;
            if (page_refs[pg] == 0) begin
              page_stack[stack_depth] = PAGE_W'(pg);
              stack_depth++;
              r.released = 1'b1;
            end
          end
        end
      end
      ACT_REFINC: begin
        r.status = chk;
        if (chk == ST_OK) begin
          if (page_refs[pg] == COUNT_MAX) r.status = ST_OVERFLOW;
          else page_refs[pg]++;
        end
      end
      default: begin
        stack_depth = '0;
        for (p = 32'(first_page); p < PAGES; p++) begin
          page_refs[p] = '0;
          page_stack[stack_depth] = PAGE_W'(p);
          stack_depth++;
        end
      end
    endcase
    r.free_pages = stack_depth;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors_seen++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    page_result_t want;
    if (!rst_n) begin
      stack_depth = '0;
      first_page  = '0;
      for (int i = 0; i < PAGES; i++) page_refs[i] = '0;
      expected_page_results.delete();
      outstanding <= 0;
    end else begin
      if (cfg_write_en) first_page = cfg_write_data;
      // Results leave before the new item is predicted, since a result
      // accepted at this edge always belongs to an earlier item.
      if (out_valid && out_ready) begin
        if (expected_page_results.size() == 0) begin
          errors_seen++;
          $display("%0t: unexpected result, expected none, got status %0d addr %0h",
                   $time, out_status, out_page_address);
        end else begin
          want = expected_page_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("page_address", 32'(want.page_address), 32'(out_page_address));
          check_field("page_released", 32'(want.released), 32'(out_page_released));
          check_field("free_pages", 32'(want.free_pages), 32'(out_free_pages));
        end
      end
      if (in_valid && in_ready) begin
        expected_page_results.push_back(predict_page_op(in_action, in_address));
      end
      outstanding <= expected_page_results.size();
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
  import rpa_pkg::*;

  localparam int PAGES = DEF_NUM_PAGES;
  localparam int SHIFT = DEF_PAGE_SHIFT;
  localparam int HOT   = 32;

  typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_CHOKED} rx_mode_t;

  logic                   clk            = 1'b0;
  logic                   rst_n          = 1'b0;
  logic                   cfg_write_en   = 1'b0;
  logic [CFG_W-1:0]       cfg_write_data = '0;
  logic                   in_valid       = 1'b0;
  logic [ACTION_W-1:0]    in_action      = ACT_ALLOC;
  logic [ADDRESS_W-1:0]   in_address     = '0;
  logic                   out_ready      = 1'b0;
  logic                   in_ready;
  logic                   out_valid;
  logic [STATUS_W-1:0]    out_status;
  logic [PAGE_ADDR_W-1:0] out_page_address;
  logic                   out_page_released;
  logic [FREE_W-1:0]      out_free_pages;
  int                     mismatches;
  int                     outstanding;

  int                     burst_left  = 0;
  int                     init_budget = 12;
  int unsigned            cur_first   = 0;
  logic [ADDRESS_W-1:0]   live_pages[$];

  rx_mode_t               rx_mode    = RX_OPEN;
  int                     rx_left    = 0;
  int                     rx_pos     = 0;
  logic [7:0]             rx_pattern = 8'hff;

  refcounted_page_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write_en      (cfg_write_en),
    .cfg_write_data    (cfg_write_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_address        (in_address),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_page_address  (out_page_address),
    .out_page_released (out_page_released),
    .out_free_pages    (out_free_pages)
  );

  rpa_result_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write_en      (cfg_write_en),
    .cfg_write_data    (cfg_write_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_address        (in_address),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_page_address  (out_page_address),
    .out_page_released (out_page_released),
    .out_free_pages    (out_free_pages),
    .mismatches        (mismatches),
    .outstanding       (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: switches at random between stall styles.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode    = rx_mode_t'($urandom_range(0, 3));
      rx_left    = $urandom_range(32, 256);
      rx_pattern = 8'($urandom) | 8'h01;
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:    out_ready <= 1'b1;
      RX_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
      RX_PATTERN: begin
        out_ready <= rx_pattern[rx_pos];
        rx_pos = (rx_pos + 1) % 8;
      end
      default:    out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Remember recently allocated pages so that frees and increments hit them.
  always @(negedge clk) begin
    if (out_valid && out_ready && out_status == ST_OK && out_page_address != '0) begin
      live_pages.push_back({1'b0, out_page_address});
      if (live_pages.size() > 48) void'(live_pages.pop_front());
    end
  end

  function automatic logic [ADDRESS_W-1:0] page_addr(input int unsigned pg);
    return ADDRESS_W'(pg << SHIFT);
  endfunction

  function automatic logic [ADDRESS_W-1:0] pick_address();
    int unsigned          r;
    int unsigned          pg;
    logic [ADDRESS_W-1:0] a;
    r = $urandom_range(0, 99);
    if (r < 35 && live_pages.size() > 0) begin
      a = live_pages[$urandom_range(0, live_pages.size() - 1)];
    end else if (r < 70) begin
      a = page_addr(PAGES - 1 - $urandom_range(0, HOT - 1));
    end else if (r < 80) begin
      // Pages right around the first usable one.
      if (cur_first == 0) pg = $urandom_range(0, 1);
      else pg = (cur_first - 1 + $urandom_range(0, 2)) & 16'hffff;
      a = page_addr(pg);
    end else if (r < 88) begin
      a = page_addr($urandom_range(PAGES, 65535));
    end else if (r < 95) begin
      a = ADDRESS_W'($urandom);
      if (a[SHIFT-1:0] == '0) a[0] = 1'b1;
    end else begin
      a = ADDRESS_W'($urandom);
    end
    return a;
  endfunction

  function automatic logic [ACTION_W-1:0] random_action();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 36) return ACT_ALLOC;
    if (r < 68) return ACT_FREE;
    if (r < 99 || init_budget == 0) return ACT_REFINC;
    init_budget--;
    return ACT_INIT;
  endfunction

  task automatic send_item(input logic [ACTION_W-1:0] action,
                           input logic [ADDRESS_W-1:0] address);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid   <= 1'b1;
    in_action  <= action;
    in_address <= address;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  // The outstanding count is registered and lags the queue, so step the clock before looking at it.
  task automatic wait_drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_first_usable(input logic [CFG_W-1:0] value);
    cur_first = 32'(value);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  initial begin
    int unsigned          phase_first [7];
    logic [ADDRESS_W-1:0] hammered;
    phase_first = '{32760, 32700, 0, 0, 1, 32767, 16384};
    phase_first[3] = $urandom_range(30000, 32767);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    write_first_usable(CFG_W'(0));

    // Empty stack, bad addresses, and a page that is pooled and reused.
    send_item(ACT_ALLOC, ADDRESS_W'($urandom));
    send_item(ACT_FREE, page_addr(5));
    send_item(ACT_REFINC, '0);
    send_item(ACT_FREE, '0);
    send_item(ACT_ALLOC, ADDRESS_W'($urandom));
    send_item(ACT_FREE, 28'h0000001);
    send_item(ACT_REFINC, 28'hfffffff);
    send_item(ACT_FREE, page_addr(PAGES));
    send_item(ACT_REFINC, page_addr(65535));
    // Full pool: a page still on the stack is referenced and then freed, which
    // would push onto a full stack.
    send_item(ACT_INIT, ADDRESS_W'($urandom));
    send_item(ACT_REFINC, page_addr(PAGES - 1));
    send_item(ACT_FREE, page_addr(PAGES - 1));
    send_item(ACT_ALLOC, ADDRESS_W'($urandom));
    send_item(ACT_REFINC, page_addr(PAGES - 1));
    send_item(ACT_FREE, page_addr(PAGES - 1));
    send_item(ACT_FREE, page_addr(PAGES - 1));
    send_item(ACT_FREE, page_addr(PAGES - 1));
    wait_drain();
    // First usable page past the end of memory: init leaves the pool empty.
    write_first_usable(CFG_W'(PAGES));
    send_item(ACT_INIT, ADDRESS_W'($urandom));
    send_item(ACT_ALLOC, ADDRESS_W'($urandom));
    send_item(ACT_FREE, '0);
    send_item(ACT_REFINC, page_addr(PAGES - 1));
    wait_drain();
    write_first_usable(16'hffff);
    send_item(ACT_INIT, ADDRESS_W'($urandom));
    send_item(ACT_REFINC, page_addr(65535));
    send_item(ACT_FREE, page_addr(PAGES - 1));

    for (int ph = 0; ph < 7; ph++) begin
      wait_drain();
      write_first_usable(CFG_W'(phase_first[ph]));
      send_item(ACT_INIT, ADDRESS_W'($urandom));
      if (ph == 1) begin
        // Drive one count up to its limit and past it, then bring it down.
        hammered = page_addr(PAGES - 1 - $urandom_range(0, HOT - 1));
        repeat (257) send_item(ACT_REFINC, hammered);
        repeat (3) send_item(ACT_FREE, hammered);
        repeat (30) send_item(random_action(), pick_address());
      end else begin
        repeat (105) send_item(random_action(), pick_address());
      end
    end

    wait_drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
